>>> rtl/core/ljdq_pkg.sv
`default_nettype none

package ljdq_pkg;

  localparam int LEVEL_W = 12;
  localparam int CFG_INDEX_W = 4;
  localparam int EVENT_W = 3;
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_LOW  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_HIGH = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_LOW   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_HIGH  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_LOW   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_HIGH  = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_UP_LOW     = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_UP_HIGH    = 4'd7;

  localparam logic [LEVEL_W-1:0] RIGHT_LOW_RST  = 12'd100;
  localparam logic [LEVEL_W-1:0] RIGHT_HIGH_RST = 12'd700;
  localparam logic [LEVEL_W-1:0] DOWN_LOW_RST   = 12'd900;
  localparam logic [LEVEL_W-1:0] DOWN_HIGH_RST  = 12'd1500;
  localparam logic [LEVEL_W-1:0] LEFT_LOW_RST   = 12'd1700;
  localparam logic [LEVEL_W-1:0] LEFT_HIGH_RST  = 12'd2300;
  localparam logic [LEVEL_W-1:0] UP_LOW_RST     = 12'd2500;
  localparam logic [LEVEL_W-1:0] UP_HIGH_RST    = 12'd3100;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_UP      = 3'd1,
    EV_DOWN    = 3'd2,
    EV_LEFT    = 3'd3,
    EV_RIGHT   = 3'd4,
    EV_PRESS   = 3'd5,
    EV_RELEASE = 3'd6
  } event_t;

  typedef struct packed {
    logic   is_read;
    event_t ev;
  } cmd_t;

  function automatic logic in_window(input logic [LEVEL_W-1:0] v,
                                     input logic [LEVEL_W-1:0] lo,
                                     input logic [LEVEL_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ljdq_ram.sv
`default_nettype none

module ljdq_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ljdq_fifo.sv
`default_nettype none

module ljdq_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  output logic                            full,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ljdq_front.sv
`default_nettype none

module ljdq_front #(
  parameter int STABLE_COUNT = 3,
  parameter int IDLE_LEVEL   = 3600
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic                             kind,
  input  wire logic [ljdq_pkg::LEVEL_W-1:0]     ladder_level,
  input  wire logic                             pressed,
  input  wire logic                             cfg_we,
  input  wire logic [ljdq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ljdq_pkg::LEVEL_W-1:0]     cfg_data,
  output logic                                  cmd_push,
  output ljdq_pkg::cmd_t                        cmd
);

  localparam int CNT_W = $clog2(STABLE_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STABLE_COUNT);
  localparam logic [ljdq_pkg::LEVEL_W-1:0] IDLE = ljdq_pkg::LEVEL_W'(IDLE_LEVEL);

  logic [ljdq_pkg::LEVEL_W-1:0] right_low, right_high, down_low, down_high;
  logic [ljdq_pkg::LEVEL_W-1:0] left_low, left_high, up_low, up_high;

  logic [ljdq_pkg::LEVEL_W-1:0] previous_level, previous_level_next;
  logic [CNT_W-1:0]             stable_count, stable_count_next;
  logic                         previous_pressed, previous_pressed_next;
  logic [CNT_W-1:0]             cnt_inc;
  ljdq_pkg::event_t             dir_ev;
  ljdq_pkg::event_t             ev;

  always_comb begin
    priority if (ladder_level > IDLE) begin
      dir_ev = ljdq_pkg::EV_NONE;
    end else if (ljdq_pkg::in_window(ladder_level, right_low, right_high)) begin
      dir_ev = ljdq_pkg::EV_RIGHT;
    end else if (ljdq_pkg::in_window(ladder_level, down_low, down_high)) begin
      dir_ev = ljdq_pkg::EV_DOWN;
    end else if (ljdq_pkg::in_window(ladder_level, left_low, left_high)) begin
      dir_ev = ljdq_pkg::EV_LEFT;
    end else if (ljdq_pkg::in_window(ladder_level, up_low, up_high)) begin
      dir_ev = ljdq_pkg::EV_UP;
    end else begin
      dir_ev = ljdq_pkg::EV_NONE;
    end
  end

  always_comb begin
    ev                    = ljdq_pkg::EV_NONE;
    previous_level_next   = previous_level;
    stable_count_next     = stable_count;
    previous_pressed_next = previous_pressed;
    cnt_inc = (stable_count < CNT_MAX) ? stable_count + 1'b1 : stable_count;
    priority if (ladder_level != previous_level) begin
      stable_count_next   = '0;
      previous_level_next = ladder_level;
    end else if (cnt_inc < CNT_MAX) begin
      stable_count_next = cnt_inc;
    end else if (pressed != previous_pressed) begin
      previous_pressed_next = pressed;
      stable_count_next     = '0;
      ev = pressed ? ljdq_pkg::EV_PRESS : ljdq_pkg::EV_RELEASE;
    end else begin
      stable_count_next = cnt_inc;
      ev                = dir_ev;
    end
  end

  assign cmd_push    = accept && (kind || (ev != ljdq_pkg::EV_NONE));
  assign cmd.is_read = kind;
  assign cmd.ev      = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level   <= '0;
      stable_count     <= '0;
      previous_pressed <= 1'b1;
    end else if (accept && !kind) begin
      previous_level   <= previous_level_next;
      stable_count     <= stable_count_next;
      previous_pressed <= previous_pressed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_low  <= ljdq_pkg::RIGHT_LOW_RST;
      right_high <= ljdq_pkg::RIGHT_HIGH_RST;
      down_low   <= ljdq_pkg::DOWN_LOW_RST;
      down_high  <= ljdq_pkg::DOWN_HIGH_RST;
      left_low   <= ljdq_pkg::LEFT_LOW_RST;
      left_high  <= ljdq_pkg::LEFT_HIGH_RST;
      up_low     <= ljdq_pkg::UP_LOW_RST;
      up_high    <= ljdq_pkg::UP_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ljdq_pkg::CFG_RIGHT_LOW:  right_low  <= cfg_data;
        ljdq_pkg::CFG_RIGHT_HIGH: right_high <= cfg_data;
        ljdq_pkg::CFG_DOWN_LOW:   down_low   <= cfg_data;
        ljdq_pkg::CFG_DOWN_HIGH:  down_high  <= cfg_data;
        ljdq_pkg::CFG_LEFT_LOW:   left_low   <= cfg_data;
        ljdq_pkg::CFG_LEFT_HIGH:  left_high  <= cfg_data;
        ljdq_pkg::CFG_UP_LOW:     up_low     <= cfg_data;
        ljdq_pkg::CFG_UP_HIGH:    up_high    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ljdq_back.sv
`default_nettype none

module ljdq_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cmd_valid,
  input  ljdq_pkg::cmd_t                               cmd,
  output logic                                         cmd_pop,
  input  wire logic [$clog2(ljdq_pkg::RES_DEPTH+1)-1:0] res_count,
  output logic                                         res_push,
  output logic      [ljdq_pkg::EVENT_W-1:0]            res_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int RCNT_W = $clog2(ljdq_pkg::RES_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [RCNT_W:0] RES_MAX = (RCNT_W + 1)'(ljdq_pkg::RES_DEPTH);

  logic [PTR_W-1:0]             write_slot;
  logic [PTR_W-1:0]             read_slot;
  logic [PTR_W-1:0]             write_slot_next;
  logic [PTR_W-1:0]             read_slot_next;
  logic                         ring_full;
  logic                         ring_empty;
  logic                         inflight;
  logic                         rd_none;
  logic                         room;
  logic                         ram_we;
  logic                         ram_re;
  logic [ljdq_pkg::EVENT_W-1:0] ram_rdata;

  assign write_slot_next = (write_slot == LAST) ? '0 : write_slot + 1'b1;
  assign read_slot_next  = (read_slot == LAST) ? '0 : read_slot + 1'b1;
  assign ring_full  = (write_slot_next == read_slot);
  assign ring_empty = (write_slot == read_slot);

  // reads need a result slot, counting the one still in flight
  assign room    = ({1'b0, res_count} + {{RCNT_W{1'b0}}, inflight}) < RES_MAX;
  assign cmd_pop = cmd_valid && (!cmd.is_read || room);
  assign ram_we  = cmd_pop && !cmd.is_read && !ring_full;
  assign ram_re  = cmd_pop && cmd.is_read && !ring_empty;

  ljdq_ram #(
    .WIDTH (ljdq_pkg::EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (cmd.ev),
    .re    (ram_re),
    .raddr (read_slot),
    .rdata (ram_rdata)
  );

  assign res_push = inflight;
  assign res_data = rd_none ? ljdq_pkg::EV_NONE : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      read_slot  <= '0;
      inflight   <= 1'b0;
    end else begin
      inflight <= cmd_pop && cmd.is_read;
      if (ram_we) begin
        write_slot <= write_slot_next;
      end
      if (ram_re) begin
        read_slot <= read_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_read) begin
      rd_none <= ring_empty;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ladder_joystick_debounce_queue_top.sv
// Resistor-ladder joystick debounce with an event queue.
//
// Input channel (push/full): kind 0 is a sample (ladder_level, pressed),
// kind 1 is a read request that pops one queued event. An item is taken
// when push is high and full is low; one item per cycle is sustained.
// Result channel (empty/pop): one event_code per read request, in order,
// 0 when no event was queued. Samples give no result.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0..7
// selects a window bound, other indexes are ignored. Write only when idle.
// A read request passes the command queue, the ring read register and the result queue before its result shows.
// Rate: one item per clock while full is low, set by the combinational
// classifier in the front end and one ring access per cycle in the back end.
// A stalled receiver fills the result queue, then the command queue, and
// full rises; nothing is lost. Events past QUEUE_DEPTH-1 stored are dropped.
// Reset (rst, synchronous) empties all queues, restores the window bounds
// and clears the debounce state; the event ring contents are left as is.
`default_nettype none

module ladder_joystick_debounce_queue_top #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int STABLE_COUNT = 3,
  parameter int IDLE_LEVEL   = 3600
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic                             kind,
  input  wire logic [ljdq_pkg::LEVEL_W-1:0]     ladder_level,
  input  wire logic                             pressed,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic      [ljdq_pkg::EVENT_W-1:0]     event_code,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ljdq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ljdq_pkg::LEVEL_W-1:0]     cfg_data
);

  localparam int RCNT_W = $clog2(ljdq_pkg::RES_DEPTH + 1);
  localparam int CCNT_W = $clog2(ljdq_pkg::CMD_DEPTH + 1);

  logic                         accept;
  logic                         cmd_push;
  ljdq_pkg::cmd_t               cmd_in;
  ljdq_pkg::cmd_t               cmd_out;
  logic                         cmd_empty;
  logic                         cmd_pop;
  logic [CCNT_W-1:0]            cmd_count;
  logic                         res_push;
  logic [ljdq_pkg::EVENT_W-1:0] res_data;
  logic                         res_full;
  logic [RCNT_W-1:0]            res_count;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  ljdq_front #(
    .STABLE_COUNT (STABLE_COUNT),
    .IDLE_LEVEL   (IDLE_LEVEL)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (kind),
    .ladder_level (ladder_level),
    .pressed      (pressed),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  ljdq_fifo #(
    .WIDTH ($bits(ljdq_pkg::cmd_t)),
    .DEPTH (ljdq_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  ljdq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  ljdq_fifo #(
    .WIDTH (ljdq_pkg::EVENT_W),
    .DEPTH (ljdq_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (event_code),
    .empty (empty),
    .count (res_count)
  );

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_read_queued: assert property (@(posedge clk) disable iff (rst)
    (accept && kind) |=> !cmd_empty)
    else $error("accepted read request missing from command queue");

  a_res_from_read: assert property (@(posedge clk) disable iff (rst)
    res_push |-> $past(cmd_pop && cmd_out.is_read))
    else $error("result without a preceding read request");

  a_cmd_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= ljdq_pkg::CMD_DEPTH)
    else $error("command queue count out of range");

endmodule

`default_nettype wire

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH       = 16;
  localparam int STABLE_N     = 3;
  localparam int IDLE_LVL     = 3600;
  localparam int N_BOUNDS     = 8;
  localparam int IDLE_PCT     = 37;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic                         kind;
    logic [ljdq_pkg::LEVEL_W-1:0] level;
    logic                         pressed;
  } request_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             push = 1'b0;
  logic                             kind = KIND_SAMPLE;
  logic [ljdq_pkg::LEVEL_W-1:0]     ladder_level = '0;
  logic                             pressed = 1'b0;
  logic                             pop = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic [ljdq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ljdq_pkg::LEVEL_W-1:0]     cfg_data = '0;
  logic                             full;
  logic                             empty;
  logic                             cfg_ready;
  logic [ljdq_pkg::EVENT_W-1:0]     event_code;

  // debounce and ring state as the block should hold it
  logic [ljdq_pkg::LEVEL_W-1:0] win_bound [N_BOUNDS];
  logic [ljdq_pkg::LEVEL_W-1:0] last_level;
  int unsigned                  steady_cnt;
  logic                         last_pressed;
  ljdq_pkg::event_t             ring_mem [QDEPTH];
  int unsigned                  ring_wr;
  int unsigned                  ring_rd;

  request_t         req_queue [$];
  ljdq_pkg::event_t expected_events [$];
  int               errors = 0;
  int               cycle_count = 0;
  bit               no_idle = 1'b0;
  bit               hold_req = 1'b0;

  ladder_joystick_debounce_queue_top DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .ladder_level (ladder_level),
    .pressed      (pressed),
    .empty        (empty),
    .pop          (pop),
    .event_code   (event_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void reset_model();
    win_bound[ljdq_pkg::CFG_RIGHT_LOW]  = ljdq_pkg::RIGHT_LOW_RST;
    win_bound[ljdq_pkg::CFG_RIGHT_HIGH] = ljdq_pkg::RIGHT_HIGH_RST;
    win_bound[ljdq_pkg::CFG_DOWN_LOW]   = ljdq_pkg::DOWN_LOW_RST;
    win_bound[ljdq_pkg::CFG_DOWN_HIGH]  = ljdq_pkg::DOWN_HIGH_RST;
    win_bound[ljdq_pkg::CFG_LEFT_LOW]   = ljdq_pkg::LEFT_LOW_RST;
    win_bound[ljdq_pkg::CFG_LEFT_HIGH]  = ljdq_pkg::LEFT_HIGH_RST;
    win_bound[ljdq_pkg::CFG_UP_LOW]     = ljdq_pkg::UP_LOW_RST;
    win_bound[ljdq_pkg::CFG_UP_HIGH]    = ljdq_pkg::UP_HIGH_RST;
    last_level   = '0;
    steady_cnt   = 0;
    last_pressed = 1'b1;
    ring_wr      = 0;
    ring_rd      = 0;
    foreach (ring_mem[i]) ring_mem[i] = ljdq_pkg::EV_NONE;
  endfunction

  function automatic bit between(input logic [ljdq_pkg::LEVEL_W-1:0] v,
                                 input logic [ljdq_pkg::CFG_INDEX_W-1:0] lo_idx,
                                 input logic [ljdq_pkg::CFG_INDEX_W-1:0] hi_idx);
    return (v > win_bound[lo_idx]) && (v < win_bound[hi_idx]);
  endfunction

  function automatic ljdq_pkg::event_t classify_sample(input logic [ljdq_pkg::LEVEL_W-1:0] level,
                                                       input logic prs);
    if (level != last_level) begin
      steady_cnt = 0;
      last_level = level;
      return ljdq_pkg::EV_NONE;
    end
    if (steady_cnt < STABLE_N) steady_cnt++;
    if (steady_cnt < STABLE_N) return ljdq_pkg::EV_NONE;
    if (prs != last_pressed) begin
      last_pressed = prs;
      steady_cnt = 0;
      return prs ? ljdq_pkg::EV_PRESS : ljdq_pkg::EV_RELEASE;
    end
    if (level > IDLE_LVL) return ljdq_pkg::EV_NONE;
    if (between(level, ljdq_pkg::CFG_RIGHT_LOW, ljdq_pkg::CFG_RIGHT_HIGH))
      return ljdq_pkg::EV_RIGHT;
    if (between(level, ljdq_pkg::CFG_DOWN_LOW, ljdq_pkg::CFG_DOWN_HIGH))
      return ljdq_pkg::EV_DOWN;
    if (between(level, ljdq_pkg::CFG_LEFT_LOW, ljdq_pkg::CFG_LEFT_HIGH))
      return ljdq_pkg::EV_LEFT;
    if (between(level, ljdq_pkg::CFG_UP_LOW, ljdq_pkg::CFG_UP_HIGH))
      return ljdq_pkg::EV_UP;
    return ljdq_pkg::EV_NONE;
  endfunction

  function automatic void apply_request(input request_t r);
    ljdq_pkg::event_t ev;
    int unsigned      nxt;
    if (r.kind == KIND_SAMPLE) begin
      ev = classify_sample(r.level, r.pressed);
      if (ev != ljdq_pkg::EV_NONE) begin
        nxt = (ring_wr + 1) % QDEPTH;
        if (nxt != ring_rd) begin
          ring_mem[ring_wr] = ev;
          ring_wr = nxt;
        end
      end
    end else if (ring_rd == ring_wr) begin
      expected_events.push_back(ljdq_pkg::EV_NONE);
    end else begin
      expected_events.push_back(ring_mem[ring_rd]);
      ring_rd = (ring_rd + 1) % QDEPTH;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_event(input logic [ljdq_pkg::EVENT_W-1:0] got);
    ljdq_pkg::event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("event_code %0d with no read pending", got));
    end else begin
      want = expected_events.pop_front();
      if (got !== want)
        report_mismatch($sformatf("event_code %0d, expected %0d", got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) check_event(event_code);
      if (push && !full) begin
        apply_request(req_queue[0]);
        void'(req_queue.pop_front());
      end
      if (cfg_valid && cfg_ready && cfg_index < N_BOUNDS) win_bound[cfg_index] = cfg_data;
    end
  end

  initial begin : drive_requests
    forever begin
      @(negedge clk);
      if (!rst && req_queue.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        push         <= 1'b1;
        kind         <= req_queue[0].kind;
        ladder_level <= req_queue[0].level;
        pressed      <= req_queue[0].pressed;
      end else begin
        push <= 1'b0;
      end
    end
  end

  initial begin : drive_pop
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (no_idle || $urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic k, input logic [ljdq_pkg::LEVEL_W-1:0] lvl,
                           input logic prs);
    request_t r;
    r.kind    = k;
    r.level   = lvl;
    r.pressed = prs;
    while (req_queue.size() >= 4) @(posedge clk);
    req_queue.push_back(r);
  endtask

  task automatic send_read();
    send_item(KIND_READ, 12'($urandom_range(4095)), 1'($urandom_range(1)));
  endtask

  task automatic send_held(input logic [ljdq_pkg::LEVEL_W-1:0] lvl, input logic prs,
                           input int reps);
    repeat (reps) send_item(KIND_SAMPLE, lvl, prs);
  endtask

  // all requests accepted, all reads answered, pipeline empty
  task automatic settle();
    while (req_queue.size() != 0 || expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_bounds(input int rl, input int rh, input int dl, input int dh,
                             input int ll, input int lh, input int ul, input int uh);
    logic [ljdq_pkg::LEVEL_W-1:0] vals [N_BOUNDS];
    vals[ljdq_pkg::CFG_RIGHT_LOW]  = 12'(rl);
    vals[ljdq_pkg::CFG_RIGHT_HIGH] = 12'(rh);
    vals[ljdq_pkg::CFG_DOWN_LOW]   = 12'(dl);
    vals[ljdq_pkg::CFG_DOWN_HIGH]  = 12'(dh);
    vals[ljdq_pkg::CFG_LEFT_LOW]   = 12'(ll);
    vals[ljdq_pkg::CFG_LEFT_HIGH]  = 12'(lh);
    vals[ljdq_pkg::CFG_UP_LOW]     = 12'(ul);
    vals[ljdq_pkg::CFG_UP_HIGH]    = 12'(uh);
    settle();
    for (int i = 0; i <= N_BOUNDS; i++) begin
      cfg_valid <= 1'b1;
      if (i < N_BOUNDS) begin
        cfg_index <= ljdq_pkg::CFG_INDEX_W'(i);
        cfg_data  <= vals[i];
      end else begin
        // out-of-range index, must be ignored
        cfg_index <= ljdq_pkg::CFG_INDEX_W'($urandom_range(15, N_BOUNDS));
        cfg_data  <= 12'($urandom_range(4095));
      end
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_bounds();
    load_bounds($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                $urandom_range(4095), $urandom_range(4095));
  endtask

  task automatic load_reset_bounds();
    load_bounds(ljdq_pkg::RIGHT_LOW_RST, ljdq_pkg::RIGHT_HIGH_RST,
                ljdq_pkg::DOWN_LOW_RST, ljdq_pkg::DOWN_HIGH_RST,
                ljdq_pkg::LEFT_LOW_RST, ljdq_pkg::LEFT_HIGH_RST,
                ljdq_pkg::UP_LOW_RST, ljdq_pkg::UP_HIGH_RST);
  endtask

  function automatic logic [ljdq_pkg::LEVEL_W-1:0] pick_level();
    int unsigned lo;
    int unsigned hi;
    int unsigned w;
    case ($urandom_range(9))
      0: return 12'($urandom_range(4095));
      1, 2: return 12'(win_bound[$urandom_range(N_BOUNDS - 1)] + $urandom_range(2) - 1);
      3: return 12'(IDLE_LVL + $urandom_range(2) - 1);
      4: return $urandom_range(1) ? 12'hFFF : 12'h000;
      default: begin
        w  = $urandom_range(3);
        lo = win_bound[2 * w];
        hi = win_bound[2 * w + 1];
        if (hi > lo + 1) return 12'(lo + 1 + $urandom_range(hi - lo - 2));
        return 12'($urandom_range(4095));
      end
    endcase
  endfunction

  // mostly held readings with interleaved reads, some noise and press flips
  task automatic run_held_sequences(input int n_items, input int read_pct);
    int                           sent;
    int                           reps;
    logic [ljdq_pkg::LEVEL_W-1:0] lvl;
    logic                         prs;
    sent = 0;
    prs  = 1'($urandom_range(1));
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_item(KIND_SAMPLE, 12'($urandom_range(4095)), 1'($urandom_range(1)));
          sent++;
        end
        1: begin
          send_read();
          sent++;
        end
        default: begin
          lvl  = pick_level();
          reps = $urandom_range(8, 2);
          if ($urandom_range(3) == 0) prs = ~prs;
          repeat (reps) begin
            if ($urandom_range(9) == 0) prs = ~prs;
            send_item(KIND_SAMPLE, lvl, prs);
            sent++;
            if ($urandom_range(99) < read_pct) begin
              send_read();
              sent++;
            end
          end
        end
      endcase
    end
  endtask

  task automatic test_directed_events();
    send_read();
    send_held(12'd400, 1'b1, 4);
    send_held(12'd2800, 1'b1, 4);
    send_held(12'd1200, 1'b0, 4);
    send_held(12'd1200, 1'b0, 3);
    send_held(12'd2000, 1'b0, 4);
    send_held(12'd4095, 1'b1, 4);
    repeat (7) send_read();
    settle();
  endtask

  task automatic test_window_settings();
    load_bounds(0, 4095, 0, 4095, 0, 4095, 0, 4095);
    run_held_sequences(30, 30);
    load_bounds(4095, 0, 0, 0, 4095, 4095, 2000, 1000);
    run_held_sequences(25, 30);
    load_bounds(100, 700, 600, 1500, 3000, 3700, 3500, 4095);
    send_held(12'd3650, 1'b1, 5);
    send_held(12'd3600, 1'b1, 5);
    repeat (4) send_read();
    run_held_sequences(25, 30);
    load_bounds(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    run_held_sequences(20, 30);
    repeat (3) begin
      load_random_bounds();
      run_held_sequences(20, 30);
    end
    settle();
  endtask

  task automatic test_ring_overflow();
    load_reset_bounds();
    send_held(12'd1000, last_pressed, 22);
    run_held_sequences(30, 3);
    repeat (20) send_read();
    settle();
  endtask

  task automatic test_receiver_stall();
    send_held(12'd500, last_pressed, 12);
    hold_req = 1'b1;
    repeat (30) begin
      send_read();
      if ($urandom_range(2) == 0) send_item(KIND_SAMPLE, 12'd500, last_pressed);
    end
    // sender waits here for every read to be answered
    settle();
  endtask

  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    run_held_sequences(45, 35);
    settle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_mixed();
    load_random_bounds();
    run_held_sequences(35, 25);
    load_reset_bounds();
    run_held_sequences(35, 25);
    settle();
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_events();
    test_window_settings();
    test_ring_overflow();
    test_receiver_stall();
    test_no_idle_stretch();
    test_random_mixed();
    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
